// File: hw/rtl/first_fit_heap_allocator_unit_defines.svh
// assertion macros for the first-fit heap allocator
// expects i_clk and i_rst_n in the scope of each use
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

`endif

// File: hw/rtl/ffha_pkg.sv
// shared types and codes for the first-fit heap allocator
// no dependencies
package ffha_pkg;

    localparam int KIND_W   = 1;
    localparam int SIZE_W   = 13;
    localparam int OFFS_W   = 13;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [OFFS_W-1:0]   t_offs;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_ALLOC = 1'b0;
    localparam t_kind KIND_FREE  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_SPACE = 2'd1;
    localparam t_status ST_BAD_PTR  = 2'd2;

endpackage

// File: hw/rtl/ffha_intf.sv
// request and response channel interfaces of the heap allocator
// depends on ffha_pkg
interface ffha_req_if;
    import ffha_pkg::*;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_size request_size;
    t_offs pointer_offset;

    modport source (output valid, kind, request_size, pointer_offset, input ready);
    modport sink   (input valid, kind, request_size, pointer_offset, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_offs   payload_offset;

    modport source (output valid, status, payload_offset, input ready);
    modport sink   (input valid, status, payload_offset, output ready);
endinterface

// File: hw/rtl/ffha_hdr_ram.sv
// block header memory: one write port, one read port, registered read data
// no dependencies
module ffha_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 13,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ffha_ctrl.sv
// block chain walker: allocate search and split, free lookup, merge pass
// depends on ffha_pkg and ffha_intf; drives ffha_hdr_ram
module ffha_ctrl #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    localparam int AW          = $clog2(HEAP_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ffha_req_if.sink      i_req,
    ffha_rsp_if.source    o_rsp,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [AW:0]   o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [AW:0]   i_mem_rdata
);
    import ffha_pkg::*;

    localparam int SW = AW + 1;
    localparam int CW = ((AW > OFFS_W) ? AW : OFFS_W) + 2;
    localparam logic [SW-1:0] HEAP_SUM = SW'(HEAP_BYTES);
    localparam logic [SW-1:0] HDR_SUM  = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] HEAP_CMP = CW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR_CMP  = CW'(HEADER_BYTES);
    localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ACHK   = 4'd2;
    localparam logic [3:0] S_ASPLIT = 4'd3;
    localparam logic [3:0] S_FCHK   = 4'd4;
    localparam logic [3:0] S_MBEGIN = 4'd5;
    localparam logic [3:0] S_MCUR   = 4'd6;
    localparam logic [3:0] S_MNXT   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]    r_state, n_state;
    t_size         r_req, n_req;
    t_offs         r_ptr, n_ptr;
    logic [SW-1:0] r_h, n_h;
    logic [SW-1:0] r_n, n_n;
    logic [AW-1:0] r_cur_size, n_cur_size;
    logic          r_cur_free, n_cur_free;
    logic          r_dirty, n_dirty;
    logic [AW-1:0] r_split_addr, n_split_addr;
    logic [AW-1:0] r_split_size, n_split_size;
    t_status       r_status, n_status;
    t_offs         r_payload, n_payload;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    t_offs         r_out_payload, n_out_payload;

    logic          q_free;
    logic [AW-1:0] q_size;
    logic [SW-1:0] walk_next;
    logic [SW-1:0] probe_next;
    logic [SW-1:0] merged_sum;
    logic [SW-1:0] payload_sum;
    logic [SW-1:0] split_sum;
    logic [CW-1:0] req_cmp;
    logic [CW-1:0] size_cmp;
    logic [CW-1:0] ptr_cmp;
    logic [CW-1:0] in_ptr_cmp;
    logic [CW-1:0] pay_cmp;
    logic          accept;
    logic          out_load;

    assign q_free      = i_mem_rdata[AW];
    assign q_size      = i_mem_rdata[AW-1:0];
    assign walk_next   = r_h + HDR_SUM + SW'(q_size);
    assign probe_next  = r_n + HDR_SUM + SW'(q_size);
    assign merged_sum  = SW'(r_cur_size) + HDR_SUM + SW'(q_size);
    assign payload_sum = r_h + HDR_SUM;
    assign split_sum   = r_h + HDR_SUM + SW'(r_req);
    assign req_cmp     = CW'(r_req);
    assign size_cmp    = CW'(q_size);
    assign ptr_cmp     = CW'(r_ptr);
    assign in_ptr_cmp  = CW'(i_req.pointer_offset);
    assign pay_cmp     = CW'(payload_sum);

    assign i_req.ready          = (r_state == S_IDLE);
    assign accept               = i_req.valid && i_req.ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.payload_offset = r_out_payload;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_ptr        = r_ptr;
        n_h          = r_h;
        n_n          = r_n;
        n_cur_size   = r_cur_size;
        n_cur_free   = r_cur_free;
        n_dirty      = r_dirty;
        n_split_addr = r_split_addr;
        n_split_size = r_split_size;
        n_status     = r_status;
        n_payload    = r_payload;
        out_load     = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_h[AW-1:0];
        o_mem_wdata  = {r_cur_free, r_cur_size};
        o_mem_raddr  = r_h[AW-1:0];

        unique case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = {1'b1, INIT_SIZE};
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                o_mem_raddr = '0;
                if (accept) begin
                    n_req     = i_req.request_size;
                    n_ptr     = i_req.pointer_offset;
                    n_h       = '0;
                    n_payload = '0;
                    if (i_req.kind == KIND_ALLOC) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_ACHK;
                    end else begin
                        n_status = ST_BAD_PTR;
                        if (in_ptr_cmp >= HDR_CMP && in_ptr_cmp < HEAP_CMP) begin
                            n_state = S_FCHK;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_ACHK: begin
                if (q_free && size_cmp >= req_cmp) begin
                    n_state = S_DONE;
                    if (size_cmp == req_cmp) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {1'b0, q_size};
                        n_status    = ST_OK;
                        n_payload   = OFFS_W'(payload_sum);
                    end else if (size_cmp > req_cmp + HDR_CMP) begin
                        o_mem_we     = 1'b1;
                        o_mem_wdata  = {1'b0, AW'(r_req)};
                        n_split_addr = split_sum[AW-1:0];
                        n_split_size = q_size - AW'(r_req) - AW'(HEADER_BYTES);
                        n_status     = ST_OK;
                        n_payload    = OFFS_W'(payload_sum);
                        n_state      = S_ASPLIT;
                    end
                end else if (walk_next >= HEAP_SUM) begin
                    n_state = S_DONE;
                end else begin
                    n_h         = walk_next;
                    o_mem_raddr = walk_next[AW-1:0];
                end
            end
            S_ASPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_split_addr;
                o_mem_wdata = {1'b1, r_split_size};
                n_state     = S_DONE;
            end
            S_FCHK: begin
                if (pay_cmp == ptr_cmp) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = {1'b1, q_size};
                    n_status    = ST_OK;
                    n_state     = S_MBEGIN;
                end else if (pay_cmp > ptr_cmp || walk_next >= HEAP_SUM) begin
                    n_state = S_DONE;
                end else begin
                    n_h         = walk_next;
                    o_mem_raddr = walk_next[AW-1:0];
                end
            end
            S_MBEGIN: begin
                o_mem_raddr = '0;
                n_h         = '0;
                n_state     = S_MCUR;
            end
            S_MCUR: begin
                n_cur_free = q_free;
                n_cur_size = q_size;
                n_dirty    = 1'b0;
                if (walk_next >= HEAP_SUM) begin
                    n_state = S_DONE;
                end else begin
                    n_n         = walk_next;
                    o_mem_raddr = walk_next[AW-1:0];
                    n_state     = S_MNXT;
                end
            end
            S_MNXT: begin
                o_mem_raddr = probe_next[AW-1:0];
                if (r_cur_free && q_free) begin
                    n_cur_size = merged_sum[AW-1:0];
                    n_dirty    = 1'b1;
                    if (probe_next >= HEAP_SUM) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {r_cur_free, merged_sum[AW-1:0]};
                        n_state     = S_DONE;
                    end else begin
                        n_n = probe_next;
                    end
                end else begin
                    o_mem_we   = r_dirty;
                    n_h        = r_n;
                    n_cur_free = q_free;
                    n_cur_size = q_size;
                    n_dirty    = 1'b0;
                    if (probe_next >= HEAP_SUM) begin
                        n_state = S_DONE;
                    end else begin
                        n_n = probe_next;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_payload = r_out_payload;
        if (out_load) begin
            n_out_valid   = 1'b1;
            n_out_status  = r_status;
            n_out_payload = r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_ptr         <= n_ptr;
        r_h           <= n_h;
        r_n           <= n_n;
        r_cur_size    <= n_cur_size;
        r_cur_free    <= n_cur_free;
        r_dirty       <= n_dirty;
        r_split_addr  <= n_split_addr;
        r_split_size  <= n_split_size;
        r_status      <= n_status;
        r_payload     <= n_payload;
        r_out_status  <= n_out_status;
        r_out_payload <= n_out_payload;
    end

endmodule

// File: hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator. Each request beat on i_req gives exactly one response beat on
// o_rsp. An allocate walks the block headers up to the first free block that is large
// enough, then writes a split remainder header if there is one. A free walks the blocks
// up to the freed block, then runs a merge pass over the whole chain; an out-of-heap
// pointer completes without a walk. Every walk reads headers through the single read
// port of the header memory, one entry per cycle. After reset the block writes the
// initial free-block header at offset 0 before it accepts a request; other header
// entries are never read before they are written and need no clearing. A new request
// is accepted while the previous response still waits in the output register.
// depends on ffha_pkg, ffha_intf, ffha_ctrl and ffha_hdr_ram
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);

    localparam int AW = $clog2(HEAP_BYTES);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [AW:0]   mem_rdata;

    ffha_ctrl #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ffha_hdr_ram #(
        .DEPTH (HEAP_BYTES),
        .WIDTH (AW + 1)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// File: hw/rtl/ffha_checker.sv
// port-level checks for the heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator_unit_defines.svh
`include "first_fit_heap_allocator_unit_defines.svh"

module ffha_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input ffha_pkg::t_status i_rsp_status,
    input ffha_pkg::t_offs   i_rsp_payload_offset
);
    import ffha_pkg::*;

    `FFHA_ASSERT_IMP(a_fail_no_payload, i_rsp_valid && i_rsp_status != ST_OK, i_rsp_payload_offset == '0)
    `FFHA_ASSERT_NXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready)
    `FFHA_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_payload_offset))

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_status         (o_rsp.status),
    .i_rsp_payload_offset (o_rsp.payload_offset)
);

// File: dv/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for first_fit_heap_allocator_unit: directed and random
// allocate/free beats checked against an internal header-chain predictor
// depends on ffha_pkg, ffha_intf and the allocator rtl
module first_fit_heap_allocator_unit_tb;
    import ffha_pkg::*;

    localparam int HEAP_BYTES  = 4096;
    localparam int HDR_BYTES   = 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_status status;
        t_offs   payload_offset;
    } t_heap_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator_unit #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HDR_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // predicted header chain
    int unsigned hdr_size [HEAP_BYTES];
    bit          hdr_free [HEAP_BYTES];

    t_heap_rsp   expected_rsps[$];
    t_heap_rsp   last_prediction;
    t_heap_rsp   rsp_want;
    t_offs       live_ptrs[$];
    t_offs       freed_ptrs[$];
    int unsigned mismatch_count = 0;
    int unsigned rsp_beats = 0;
    int unsigned rsp_stall_left = 0;
    int unsigned hold_pending = 0;
    bit          idle_on = 1'b0;

    function automatic void heap_reset();
        foreach (hdr_size[i]) begin
            hdr_size[i] = 0;
            hdr_free[i] = 1'b0;
        end
        hdr_size[0] = HEAP_BYTES - HDR_BYTES;
        hdr_free[0] = 1'b1;
    endfunction

    function automatic int unsigned chain_next(int unsigned h);
        return h + HDR_BYTES + hdr_size[h];
    endfunction

    function automatic void coalesce_heap();
        int unsigned h;
        int unsigned n;
        h = 0;
        while (h < HEAP_BYTES) begin
            n = chain_next(h);
            if (n >= HEAP_BYTES) break;
            if (hdr_free[h] && hdr_free[n]) begin
                hdr_size[h] += HDR_BYTES + hdr_size[n];
                hdr_size[n] = 0;
                hdr_free[n] = 1'b0;
            end else begin
                h = n;
            end
        end
    endfunction

    function automatic t_heap_rsp heap_step(t_kind kind, t_size req_size, t_offs ptr);
        t_heap_rsp   res;
        int unsigned h;
        int unsigned n;
        int unsigned req;
        int unsigned p;
        req = req_size;
        h = 0;
        res.status = ST_BAD_PTR;
        res.payload_offset = '0;
        if (kind == KIND_ALLOC) begin
            while (h < HEAP_BYTES) begin
                if (hdr_free[h] && hdr_size[h] >= req) break;
                h = chain_next(h);
            end
            if (h >= HEAP_BYTES) begin
                res.status = ST_NO_SPACE;
            end else if (hdr_size[h] == req) begin
                hdr_free[h] = 1'b0;
                res.status = ST_OK;
                res.payload_offset = t_offs'(h + HDR_BYTES);
            end else if (hdr_size[h] > req + HDR_BYTES) begin
                n = h + HDR_BYTES + req;
                hdr_size[n] = hdr_size[h] - req - HDR_BYTES;
                hdr_free[n] = 1'b1;
                hdr_size[h] = req;
                hdr_free[h] = 1'b0;
                res.status = ST_OK;
                res.payload_offset = t_offs'(h + HDR_BYTES);
            end else begin
                res.status = ST_NO_SPACE;
            end
        end else if (ptr >= HDR_BYTES && ptr < HEAP_BYTES) begin
            while (h < HEAP_BYTES) begin
                p = h + HDR_BYTES;
                if (p == ptr) begin
                    hdr_free[h] = 1'b1;
                    coalesce_heap();
                    res.status = ST_OK;
                    break;
                end
                if (p > ptr) break;
                h = chain_next(h);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < 40)
            $display("mismatch at response beat %0d: %s got %0d want %0d",
                     rsp_beats, what, got, want);
        mismatch_count++;
    endtask

    // one request beat; prediction taken at the accepting edge
    task automatic send_request(t_kind kind, t_size req_size, t_offs ptr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.request_size   <= req_size;
        req_ch.pointer_offset <= ptr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        last_prediction = heap_step(kind, req_size, ptr);
        expected_rsps.push_back(last_prediction);
        if (kind == KIND_ALLOC && last_prediction.status == ST_OK)
            live_ptrs.push_back(last_prediction.payload_offset);
    endtask

    task automatic test_boundaries();
        t_offs whole;
        send_request(KIND_ALLOC, 13'd8191, '0);
        send_request(KIND_ALLOC, 13'd4081, '0);
        send_request(KIND_ALLOC, 13'd4080, '0);   // exact fit of the whole heap
        whole = last_prediction.payload_offset;
        send_request(KIND_ALLOC, 13'd0, '0);
        send_request(KIND_FREE, '0, whole);
        send_request(KIND_FREE, '0, whole);       // already free
        send_request(KIND_ALLOC, 13'd4065, '0);   // remainder too small for a header
        send_request(KIND_ALLOC, 13'd4063, '0);
        send_request(KIND_FREE, '0, whole);
        send_request(KIND_FREE, '0, 13'd0);
        send_request(KIND_FREE, '0, 13'd15);
        send_request(KIND_FREE, '0, 13'd4096);
        send_request(KIND_FREE, '0, 13'd8191);
        send_request(KIND_FREE, '0, 13'd17);      // not a payload start
        send_request(KIND_ALLOC, 13'd0, '0);
        send_request(KIND_ALLOC, 13'd0, '0);
        send_request(KIND_FREE, '0, 13'd32);
        send_request(KIND_FREE, '0, 13'd16);
        live_ptrs.delete();
    endtask

    task automatic test_fit_rules();
        t_offs blk_a;
        t_offs blk_b;
        send_request(KIND_ALLOC, 13'd100, '0);
        blk_a = last_prediction.payload_offset;
        send_request(KIND_ALLOC, 13'd50, '0);
        blk_b = last_prediction.payload_offset;
        send_request(KIND_FREE, '0, blk_a);
        send_request(KIND_ALLOC, 13'd90, '0);     // first fit found but not usable
        send_request(KIND_ALLOC, 13'd84, '0);     // remainder of exactly one header
        send_request(KIND_ALLOC, 13'd100, '0);    // exact fit
        send_request(KIND_FREE, '0, blk_a);
        send_request(KIND_ALLOC, 13'd83, '0);     // split
        send_request(KIND_FREE, '0, blk_b);
        send_request(KIND_FREE, '0, blk_a);
        live_ptrs.delete();
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned pick;
        int unsigned idx;
        t_size       sz;
        t_offs       ptr;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_request(t_kind'($urandom_range(0, 1)), t_size'($urandom_range(0, 8191)),
                             t_offs'($urandom_range(0, 8191)));
            end else if (live_ptrs.size() != 0 && (pick < 50 || live_ptrs.size() > 24)) begin
                idx = $urandom_range(0, live_ptrs.size() - 1);
                ptr = live_ptrs[idx];
                live_ptrs.delete(idx);
                freed_ptrs.push_back(ptr);
                if (freed_ptrs.size() > 8) void'(freed_ptrs.pop_front());
                send_request(KIND_FREE, '0, ptr);
            end else if (pick < 56 && freed_ptrs.size() != 0) begin
                ptr = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
                if ($urandom_range(0, 3) == 0) ptr = ptr + t_offs'($urandom_range(1, 20));
                send_request(KIND_FREE, '0, ptr);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 7)      sz = t_size'($urandom_range(0, 128));
                else if (pick < 9) sz = t_size'($urandom_range(0, 600));
                else               sz = t_size'($urandom_range(0, 4200));
                send_request(KIND_ALLOC, sz, '0);
            end
        end
    endtask

    task automatic test_output_hold();
        hold_pending <= HOLD_CYCLES;
        test_random_traffic(30);
    endtask

    // response ready with random stall bursts and the long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_stall_left = 0;
            rsp_ch.ready <= 1'b0;
        end else if (hold_pending != 0) begin
            rsp_stall_left = hold_pending - 1;
            hold_pending <= 0;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall_left != 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            rsp_beats++;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected beat, status", rsp_ch.status, 0);
            end else begin
                rsp_want = expected_rsps.pop_front();
                if (rsp_ch.status !== rsp_want.status)
                    report_mismatch("status", rsp_ch.status, rsp_want.status);
                if (rsp_ch.payload_offset !== rsp_want.payload_offset)
                    report_mismatch("payload_offset", rsp_ch.payload_offset,
                                    rsp_want.payload_offset);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_ALLOC;
        req_ch.request_size   = '0;
        req_ch.pointer_offset = '0;
        rsp_ch.ready          = 1'b0;
        heap_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        test_boundaries();
        test_fit_rules();
        test_random_traffic(450);
        test_output_hold();
        idle_on = 1'b0;
        test_random_traffic(400);
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
